FILE: rtl/c_string_literal_escaper_unit_defines.svh
// assertion macros used by the back end of the c string literal escaper rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef C_STRING_LITERAL_ESCAPER_UNIT_DEFINES_SVH
`define C_STRING_LITERAL_ESCAPER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define CSLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CSLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSLE_ASSERT(lbl, prop, msg)
`define CSLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/csle_pkg.sv
// types, constants and the byte classifier of the c string literal escaper
// no dependencies
`timescale 1ns / 1ps

package csle_pkg;

    // configuration port
    localparam int          CFG_ADDR_W       = 3;
    localparam logic        REG_LINE_LIMIT   = 1'b0;
    localparam logic [7:0]  LINE_LIMIT_RESET = 8'd77;

    // characters
    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CH_DIGIT0    = 8'h30;
    localparam logic [7:0]  CH_DIGIT7    = 8'h37;

    // character slots of one word, emitted lowest first
    localparam int          NUM_SLOTS    = 9;
    localparam int          SLOT_OPEN    = 0;
    localparam int          SLOT_SPLIT0  = 1;
    localparam int          SLOT_SPLIT1  = 2;
    localparam int          SLOT_SEQ0    = 3;
    localparam int          SLOT_SEQ3    = 6;
    localparam int          SLOT_CLOSE   = 7;
    localparam int          SLOT_NL      = 8;

    typedef logic [3:0] slot_idx_t;

    // queue between front and back
    localparam int          FIFO_DEPTH   = 4;
    localparam int          FIFO_PTR_W   = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [2:0]      len;
        logic            short_oct;
    } csle_esc_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_mask;
        logic [3:0][7:0]      seq;
    } csle_desc_t;

    function automatic logic csle_is_plain(input logic [7:0] c);
        logic r;
        r = 1'b0;
        if (c >= 8'h30 && c <= 8'h39) r = 1'b1;
        if (c >= 8'h41 && c <= 8'h5A) r = 1'b1;
        if (c >= 8'h61 && c <= 8'h7A) r = 1'b1;
        // space ; , : . ^ - + = * / % | & [ ] ( ) { } < > # _
        unique case (c)
            8'h20, 8'h3B, 8'h2C, 8'h3A, 8'h2E, 8'h5E, 8'h2D, 8'h2B,
            8'h3D, 8'h2A, 8'h2F, 8'h25, 8'h7C, 8'h26, 8'h5B, 8'h5D,
            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h23, 8'h5F: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic csle_esc_t csle_escape(input logic [7:0] c);
        csle_esc_t  r;
        logic [7:0] letter;
        r.seq       = '0;
        r.len       = 3'd1;
        r.short_oct = 1'b0;
        unique case (c)
            8'h07:   letter = 8'h61;
            8'h08:   letter = 8'h62;
            8'h09:   letter = 8'h74;
            8'h0A:   letter = 8'h6E;
            8'h0B:   letter = 8'h76;
            8'h0C:   letter = 8'h66;
            8'h0D:   letter = 8'h72;
            8'h22:   letter = 8'h22;
            8'h27:   letter = 8'h27;
            8'h3F:   letter = 8'h3F;
            8'h5C:   letter = 8'h5C;
            default: letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
            r.seq[0] = CH_BACKSLASH;
            r.seq[1] = letter;
            r.len    = 3'd2;
        end
        else if (csle_is_plain(c)) begin
            r.seq[0] = c;
        end
        else if (c < 8'd8) begin
            r.seq[0]    = CH_BACKSLASH;
            r.seq[1]    = CH_DIGIT0 | {5'b0, c[2:0]};
            r.len       = 3'd2;
            r.short_oct = 1'b1;
        end
        else if (c < 8'd64) begin
            r.seq[0]    = CH_BACKSLASH;
            r.seq[1]    = CH_DIGIT0 | {5'b0, c[5:3]};
            r.seq[2]    = CH_DIGIT0 | {5'b0, c[2:0]};
            r.len       = 3'd3;
            r.short_oct = 1'b1;
        end
        else begin
            r.seq[0] = CH_BACKSLASH;
            r.seq[1] = CH_DIGIT0 | {6'b0, c[7:6]};
            r.seq[2] = CH_DIGIT0 | {5'b0, c[5:3]};
            r.seq[3] = CH_DIGIT0 | {5'b0, c[2:0]};
            r.len    = 3'd4;
        end
        return r;
    endfunction

endpackage

FILE: rtl/csle_front.sv
// front end: classifies each accepted byte and tracks column and octal state
// depends on csle_pkg
`timescale 1ns / 1ps

module csle_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 final_byte,
    input  logic [7:0]           line_limit,
    output csle_pkg::csle_desc_t desc
);
    import csle_pkg::*;

    logic [7:0] col_reg;
    logic [7:0] col_next;
    logic       pend_reg;
    logic       pend_next;

    csle_esc_t  esc;
    logic       opening;
    logic       split;
    logic [8:0] cnt;
    logic       close_lim;
    logic       close_fin;
    logic [3:0] seq_mask;

    always_comb
    begin
        esc     = csle_escape(in_byte);
        opening = (col_reg == 8'd0);
        // a plain octal digit right after a short octal escape needs a split
        split   = pend_reg && !opening && !esc.short_oct &&
                  esc.seq[0] >= CH_DIGIT0 && esc.seq[0] <= CH_DIGIT7;
        cnt     = {1'b0, col_reg} + {6'b0, esc.len} + (split ? 9'd2 : 9'd0);
        close_lim = (cnt >= {1'b0, line_limit});
        close_fin = final_byte && !close_lim && (cnt != 9'd0);

        unique case (esc.len)
            3'd1:    seq_mask = 4'b0001;
            3'd2:    seq_mask = 4'b0011;
            3'd3:    seq_mask = 4'b0111;
            default: seq_mask = 4'b1111;
        endcase

        desc.seq                             = esc.seq;
        desc.slot_mask[SLOT_OPEN]            = opening;
        desc.slot_mask[SLOT_SPLIT0]          = split;
        desc.slot_mask[SLOT_SPLIT1]          = split;
        desc.slot_mask[SLOT_SEQ3:SLOT_SEQ0]  = seq_mask;
        desc.slot_mask[SLOT_CLOSE]           = close_lim || close_fin;
        desc.slot_mask[SLOT_NL]              = close_lim || close_fin;

        col_next  = (close_lim || close_fin) ? 8'd0 : cnt[7:0];
        pend_next = esc.short_oct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg  <= 8'd0;
            pend_reg <= 1'b0;
        end
        else if (accept) begin
            col_reg  <= col_next;
            pend_reg <= pend_next;
        end
    end

endmodule

FILE: rtl/csle_fifo.sv
// short word queue between front and back ends
// depends on csle_pkg
`timescale 1ns / 1ps

module csle_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csle_pkg::csle_desc_t wr_data,
    input  logic                 pop,
    output csle_pkg::csle_desc_t rd_data,
    output logic                 full,
    output logic                 empty
);
    import csle_pkg::*;

    csle_desc_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W:0]     cnt_reg;
    logic [FIFO_PTR_W:0]     cnt_next;

    assign full    = (cnt_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + (FIFO_PTR_W+1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (FIFO_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: rtl/csle_back.sv
// back end: walks the character slots of each word into the output register
// depends on csle_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "c_string_literal_escaper_unit_defines.svh"

module csle_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csle_pkg::csle_desc_t q_desc,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_char,
    output logic                 last_char
);
    import csle_pkg::*;

    logic [NUM_SLOTS-1:0] cur_mask_reg;
    logic [NUM_SLOTS-1:0] cur_mask_next;
    logic [3:0][7:0]      cur_seq_reg;
    logic [3:0][7:0]      cur_seq_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_char_reg;
    logic [7:0]           out_char_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic                 out_free;
    logic                 emit;
    logic                 load;
    slot_idx_t            slot;
    slot_idx_t            seq_off;
    logic [NUM_SLOTS-1:0] mask_clr;
    logic [NUM_SLOTS-1:0] rem;
    logic [7:0]           slot_char;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = out_free && (cur_mask_reg != '0);

    always_comb
    begin
        slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (cur_mask_reg[i])
                slot = slot_idx_t'(i);
        end
        seq_off  = slot - slot_idx_t'(SLOT_SEQ0);
        mask_clr = cur_mask_reg & (cur_mask_reg - NUM_SLOTS'(1));

        unique case (slot)
            slot_idx_t'(SLOT_NL):                  slot_char = CH_NEWLINE;
            slot_idx_t'(SLOT_SEQ0), slot_idx_t'(SLOT_SEQ0 + 1),
            slot_idx_t'(SLOT_SEQ0 + 2), slot_idx_t'(SLOT_SEQ3):
                                                   slot_char = cur_seq_reg[seq_off[1:0]];
            default:                               slot_char = CH_QUOTE;
        endcase

        rem  = emit ? mask_clr : cur_mask_reg;
        // take the next word in the same cycle the last character leaves
        load = (rem == '0) && !q_empty;

        cur_mask_next = load ? q_desc.slot_mask : rem;
        cur_seq_next  = load ? q_desc.seq : cur_seq_reg;

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_free) begin
            out_valid_next = emit;
            out_char_next  = slot_char;
            out_last_next  = (mask_clr == '0);
        end
    end

    assign q_pop     = load;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_seq_reg  <= cur_seq_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    `CSLE_ASSERT(a_word_has_text, load |-> q_desc.slot_mask[SLOT_SEQ0], "word without text")
    `CSLE_ASSERT(a_emit_fills_out, emit |=> out_valid_reg, "emitted char lost")
    `CSLE_ASSERT(a_close_then_nl, cur_mask_reg[SLOT_CLOSE] |-> cur_mask_reg[SLOT_NL], "no newline")
    `CSLE_ASSERT_ALWAYS(a_no_pop_empty, q_pop |-> !q_empty, "pop from empty queue")

endmodule

FILE: rtl/c_string_literal_escaper_unit.sv
// c string literal escaper: one escaped character per cycle on the output side while out_stall is low
// an accepted byte goes through the queue and the slot mask into the output register
// each byte yields 1 to 7 characters (open quote, split, escape text, close quote,
// newline), sent one at a time through the single-character output register
// a 4-word queue lets input run ahead of output; in_stall rises when it is full
// reset (rst_n low, async): column and octal state cleared, queue empty, line_limit 77
`timescale 1ns / 1ps

module c_string_literal_escaper_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csle_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    input  logic                            final_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_char,
    output logic                            last_char
);
    import csle_pkg::*;

    logic [7:0] line_limit_reg;
    logic       cfg_wr;
    logic       in_accept;
    csle_desc_t front_desc;
    csle_desc_t q_desc;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LINE_LIMIT);
    assign prdata = (paddr[2] == REG_LINE_LIMIT) ? {24'b0, line_limit_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_limit_reg <= LINE_LIMIT_RESET;
        else if (cfg_wr)
            line_limit_reg <= pwdata[7:0];
    end

    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    csle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .line_limit (line_limit_reg),
        .desc       (front_desc)
    );

    csle_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_accept),
        .wr_data (front_desc),
        .pop     (q_pop),
        .rd_data (q_desc),
        .full    (q_full),
        .empty   (q_empty)
    );

    csle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_desc    (q_desc),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule
